// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  typedef enum logic [3:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_PUSH_BACK  = 4'd1,
    MODE_POP_FRONT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_ROTL       = 4'd4,
    MODE_ROTR       = 4'd5,
    MODE_SHL        = 4'd6,
    MODE_SHR        = 4'd7,
    MODE_REVERSE    = 4'd8,
    MODE_REMOVE     = 4'd9,
    MODE_QUERY      = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_WR,
    S_REV_RD,
    S_REV_W1,
    S_REV_W2,
    S_REM_RD,
    S_REM_WR,
    S_FETCH,
    S_DONE
  } state_t;

endpackage

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while the enable is low
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/deque_engine_with_rotate_reverse_remove.sv =====
// Steps: query goes to S_FETCH and S_DONE, push adds S_OP_WR first, pop, rotate and shift
// add S_OP_RD and S_OP_WR, reverse repeats S_REV_RD, S_REV_W1, S_REV_W2 per swapped pair, and
// remove repeats S_REM_RD, S_REM_WR per held entry. The single-write-port ring memory sequencer
// handles one transaction at a time, and a result waits in its own output register.
// Reset (rst, synchronous): queue empty, head at zero, no result pending; memory not cleared.
module deque_engine_with_rotate_reverse_remove #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         mode,
  input  logic signed [31:0] operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] taken_value,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [6:0]         entry_count,
  output logic [6:0]         removed_count,
  output logic [1:0]         error_code
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW+1:0] sum;
    sum = (AW+2)'(base) + (AW+2)'(off);
    if (sum >= (AW+2)'(DEPTH)) begin
      sum = sum - (AW+2)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  state_t                 state, state_next;
  mode_t                  op, op_next;
  logic [VALUE_WIDTH-1:0] operand, operand_next;
  logic [AW-1:0]          head, head_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          idx_lo, idx_lo_next;
  logic [CW-1:0]          idx_hi, idx_hi_next;
  logic [VALUE_WIDTH-1:0] taken, taken_next;
  logic [CW-1:0]          removed, removed_next;
  err_t                   err, err_next;

  logic [VALUE_WIDTH-1:0] out_taken, out_front, out_back;
  logic [CW-1:0]          out_count, out_removed;
  err_t                   out_err;
  logic                   out_load;

  logic                   we, re_a, re_b;
  logic [AW-1:0]          waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic                   empty, full;
  logic [AW-1:0]          head_prev, head_succ, last_addr, tail_addr, pos_lo, pos_hi;

  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign head_prev = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_succ = add_wrap(head, CW'(1));
  assign last_addr = add_wrap(head, count - CW'(1));
  assign tail_addr = add_wrap(head, count);
  assign pos_lo    = add_wrap(head, idx_lo);
  assign pos_hi    = add_wrap(head, idx_hi - CW'(1));

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    operand <= operand_next;
    idx_lo  <= idx_lo_next;
    idx_hi  <= idx_hi_next;
    taken   <= taken_next;
    removed <= removed_next;
    err     <= err_next;
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    operand_next = operand;
    head_next    = head;
    count_next   = count;
    idx_lo_next  = idx_lo;
    idx_hi_next  = idx_hi;
    taken_next   = taken;
    removed_next = removed;
    err_next     = err;
    we           = 1'b0;
    waddr        = head;
    wdata        = operand;
    re_a         = 1'b0;
    raddr_a      = head;
    re_b         = 1'b0;
    raddr_b      = last_addr;
    out_load     = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next      = mode_t'(mode);
          operand_next = VALUE_WIDTH'(operand_value);
          taken_next   = '0;
          removed_next = '0;
          err_next     = ERR_NONE;
          idx_lo_next  = '0;
          idx_hi_next  = (mode == MODE_REVERSE) ? count : '0;
          case (mode_t'(mode))
            MODE_PUSH_FRONT, MODE_PUSH_BACK: state_next = S_OP_WR;
            MODE_POP_FRONT, MODE_POP_BACK, MODE_ROTL, MODE_ROTR,
            MODE_SHL, MODE_SHR:              state_next = S_OP_RD;
            MODE_REVERSE:                    state_next = S_REV_RD;
            MODE_REMOVE:                     state_next = S_REM_RD;
            default:                         state_next = S_FETCH;
          endcase
        end
      end

      S_OP_RD: begin
        // fetch the old front and back
        re_a       = !empty;
        re_b       = !empty;
        state_next = S_OP_WR;
      end

      S_OP_WR: begin
        state_next = S_FETCH;
        case (op)
          MODE_PUSH_FRONT: begin
            if (full) begin
              err_next = ERR_FULL;
            end else begin
              we         = 1'b1;
              waddr      = head_prev;
              head_next  = head_prev;
              count_next = count + CW'(1);
            end
          end
          MODE_PUSH_BACK: begin
            if (full) begin
              err_next = ERR_FULL;
            end else begin
              we         = 1'b1;
              waddr      = tail_addr;
              count_next = count + CW'(1);
            end
          end
          default: begin
            if (empty) begin
              err_next = ERR_EMPTY;
            end else begin
              case (op)
                MODE_POP_FRONT: begin
                  taken_next = rdata_a;
                  head_next  = head_succ;
                  count_next = count - CW'(1);
                end
                MODE_POP_BACK: begin
                  taken_next = rdata_b;
                  count_next = count - CW'(1);
                end
                MODE_ROTL, MODE_SHL: begin
                  // front leaves, the slot past the old back becomes the new back
                  we        = 1'b1;
                  waddr     = tail_addr;
                  wdata     = (op == MODE_ROTL) ? rdata_a : operand;
                  head_next = head_succ;
                  if (op == MODE_SHL) begin
                    taken_next = rdata_a;
                  end
                end
                MODE_ROTR, MODE_SHR: begin
                  we        = 1'b1;
                  waddr     = head_prev;
                  wdata     = (op == MODE_ROTR) ? rdata_b : operand;
                  head_next = head_prev;
                  if (op == MODE_SHR) begin
                    taken_next = rdata_b;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        endcase
      end

      S_REV_RD: begin
        if ((idx_lo + CW'(1)) < idx_hi) begin
          re_a       = 1'b1;
          raddr_a    = pos_lo;
          re_b       = 1'b1;
          raddr_b    = pos_hi;
          state_next = S_REV_W1;
        end else begin
          state_next = S_FETCH;
        end
      end

      S_REV_W1: begin
        we         = 1'b1;
        waddr      = pos_lo;
        wdata      = rdata_b;
        state_next = S_REV_W2;
      end

      S_REV_W2: begin
        we          = 1'b1;
        waddr       = pos_hi;
        wdata       = rdata_a;
        idx_lo_next = idx_lo + CW'(1);
        idx_hi_next = idx_hi - CW'(1);
        state_next  = S_REV_RD;
      end

      S_REM_RD: begin
        // idx_lo walks the old entries, idx_hi counts the survivors
        if (idx_lo < count) begin
          re_a       = 1'b1;
          raddr_a    = pos_lo;
          state_next = S_REM_WR;
        end else begin
          removed_next = count - idx_hi;
          count_next   = idx_hi;
          state_next   = S_FETCH;
        end
      end

      S_REM_WR: begin
        if (rdata_a != operand) begin
          we          = 1'b1;
          waddr       = add_wrap(head, idx_hi);
          wdata       = rdata_a;
          idx_hi_next = idx_hi + CW'(1);
        end
        idx_lo_next = idx_lo + CW'(1);
        state_next  = S_REM_RD;
      end

      S_FETCH: begin
        re_a       = !empty;
        re_b       = !empty;
        state_next = S_DONE;
      end

      S_DONE: begin
        // hold until the output register frees up
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_taken   <= taken;
      out_front   <= empty ? '0 : rdata_a;
      out_back    <= empty ? '0 : rdata_b;
      out_count   <= count;
      out_removed <= removed;
      out_err     <= err;
    end
  end

  assign in_ready      = (state == S_IDLE);
  assign taken_value   = 32'(out_taken);
  assign front_value   = 32'(out_front);
  assign back_value    = 32'(out_back);
  assign entry_count   = 7'(out_count);
  assign removed_count = 7'(out_removed);
  assign error_code    = out_err;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // Mode codes past query; the block treats them as a query
  localparam logic [3:0] MODE_SPARE_LO = 4'd11;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  localparam int CAPACITY = 64;
  localparam int N_ITEMS = 1450;
  localparam int QUIET_FROM = 1300;
  localparam int DRAIN_AT = 700;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic [3:0]         mode;
    logic signed [31:0] operand;
    bit                 wait_drain;
    bit                 quiet;
  } deque_cmd_t;

  typedef struct {
    logic signed [31:0] taken;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [6:0]         count;
    logic [6:0]         removed;
    err_t               err;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] mode = 4'd0;
  logic signed [31:0] operand_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] taken_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [6:0] entry_count;
  logic [6:0] removed_count;
  logic [1:0] error_code;

  deque_engine_with_rotate_reverse_remove u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .taken_value   (taken_value),
    .front_value   (front_value),
    .back_value    (back_value),
    .entry_count   (entry_count),
    .removed_count (removed_count),
    .error_code    (error_code)
  );

  always #5 clk = ~clk;

  deque_cmd_t    cmd_q[$];
  deque_result_t expected_q[$];
  int n_sent = 0;
  int n_seen = 0;
  int n_errors = 0;
  bit quiet_phase = 1'b0;
  bit gen_quiet = 1'b0;

  // Predictor state: ring of words, head slot and fill level
  logic signed [31:0] ring_mem [CAPACITY];
  logic [5:0]         ring_head = '0;
  logic [6:0]         ring_fill = '0;

  function automatic deque_result_t deque_apply(logic [3:0] op, logic signed [31:0] val);
    deque_result_t r;
    logic signed [31:0] tmp;
    logic [5:0] a;
    logic [5:0] b;
    int i;
    int k;
    r.taken = '0;
    r.removed = '0;
    r.err = ERR_NONE;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (ring_fill == 7'(CAPACITY)) begin
          r.err = ERR_FULL;
        end else if (op == MODE_PUSH_FRONT) begin
          ring_head = ring_head - 6'd1;
          ring_mem[ring_head] = val;
          ring_fill = ring_fill + 7'd1;
        end else begin
          a = ring_head + ring_fill[5:0];
          ring_mem[a] = val;
          ring_fill = ring_fill + 7'd1;
        end
      end
      MODE_POP_FRONT, MODE_ROTL, MODE_SHL: begin
        if (ring_fill == 7'd0) begin
          r.err = ERR_EMPTY;
        end else begin
          tmp = ring_mem[ring_head];
          ring_head = ring_head + 6'd1;
          // the slot just past the old back receives the moved or filled word
          a = ring_head + ring_fill[5:0] - 6'd1;
          if (op == MODE_ROTL) begin
            ring_mem[a] = tmp;
          end else if (op == MODE_SHL) begin
            ring_mem[a] = val;
          end else begin
            ring_fill = ring_fill - 7'd1;
          end
          if (op != MODE_ROTL) r.taken = tmp;
        end
      end
      MODE_POP_BACK, MODE_ROTR, MODE_SHR: begin
        if (ring_fill == 7'd0) begin
          r.err = ERR_EMPTY;
        end else begin
          a = ring_head + ring_fill[5:0] - 6'd1;
          tmp = ring_mem[a];
          if (op == MODE_POP_BACK) begin
            ring_fill = ring_fill - 7'd1;
          end else begin
            ring_head = ring_head - 6'd1;
            ring_mem[ring_head] = (op == MODE_ROTR) ? tmp : val;
          end
          if (op != MODE_ROTR) r.taken = tmp;
        end
      end
      MODE_REVERSE: begin
        i = 0;
        k = ring_fill;
        while (i + 1 < k) begin
          a = ring_head + 6'(i);
          b = ring_head + 6'(k - 1);
          tmp = ring_mem[a];
          ring_mem[a] = ring_mem[b];
          ring_mem[b] = tmp;
          i++;
          k--;
        end
      end
      MODE_REMOVE: begin
        // compact survivors toward the front, keeping their order
        k = 0;
        for (i = 0; i < ring_fill; i++) begin
          a = ring_head + 6'(i);
          tmp = ring_mem[a];
          if (tmp != val) begin
            b = ring_head + 6'(k);
            ring_mem[b] = tmp;
            k++;
          end
        end
        r.removed = ring_fill - 7'(k);
        ring_fill = 7'(k);
      end
      default: ;
    endcase
    a = ring_head + ring_fill[5:0] - 6'd1;
    r.front = (ring_fill != 7'd0) ? ring_mem[ring_head] : '0;
    r.back = (ring_fill != 7'd0) ? ring_mem[a] : '0;
    r.count = ring_fill;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool [8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd42,
             32'sh55555555, 32'shaaaaaaaa};
    // favor a small pool so removes find matches
    if ($urandom_range(0, 3) != 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic queue_cmd(logic [3:0] m, logic signed [31:0] v);
    deque_cmd_t c;
    c.mode = m;
    c.operand = v;
    c.wait_drain = (cmd_q.size() == DRAIN_AT);
    c.quiet = gen_quiet || (cmd_q.size() >= QUIET_FROM);
    cmd_q = {cmd_q, c};
  endtask

  task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Driver
  int gap_left = 0;
  always @(posedge clk) begin : driver
    deque_cmd_t c;
    deque_result_t r;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        r = deque_apply(mode, operand_value);
        expected_q = {expected_q, r};
        n_sent <= n_sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].wait_drain && (in_valid || n_sent != n_seen))) begin
        c = cmd_q[0];
        cmd_q.delete(0);
        mode <= c.mode;
        operand_value <= c.operand;
        in_valid <= 1'b1;
        quiet_phase <= c.quiet;
        if (!c.quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and result checks
  int stall_left = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_seen <= n_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual count %0d", $time, entry_count);
          n_errors++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          note_field("taken_value", want.taken, taken_value);
          note_field("front_value", want.front, front_value);
          note_field("back_value", want.back, back_value);
          note_field("entry_count", 32'(want.count), 32'(entry_count));
          note_field("removed_count", 32'(want.removed), 32'(removed_count));
          note_field("error_code", 32'(want.err), 32'(error_code));
        end
      end
      // hold off once for long enough that the block backs up into its input
      if (!hold_used && n_sent >= HOLD_AFTER) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    logic [3:0] m;
    foreach (ring_mem[j]) ring_mem[j] = '0;

    // empty-queue errors and allowed operations on an empty queue, then on a short queue, and spare modes
    queue_cmd(MODE_QUERY, 32'sd0);
    queue_cmd(MODE_POP_FRONT, 32'sd0);
    queue_cmd(MODE_POP_BACK, 32'sd0);
    queue_cmd(MODE_ROTL, 32'sd0);
    queue_cmd(MODE_ROTR, 32'sd0);
    queue_cmd(MODE_SHL, 32'sd7);
    queue_cmd(MODE_SHR, 32'sd7);
    queue_cmd(MODE_REVERSE, 32'sd0);
    queue_cmd(MODE_REMOVE, 32'sd0);
    queue_cmd(MODE_PUSH_FRONT, 32'sh7fffffff);
    queue_cmd(MODE_PUSH_BACK, 32'sh80000000);
    queue_cmd(MODE_PUSH_FRONT, -32'sd1);
    queue_cmd(MODE_PUSH_BACK, 32'sd0);
    queue_cmd(MODE_ROTL, 32'sd0);
    queue_cmd(MODE_ROTR, 32'sd0);
    queue_cmd(MODE_SHL, 32'sh55555555);
    queue_cmd(MODE_SHR, 32'shaaaaaaaa);
    queue_cmd(MODE_REVERSE, 32'sd0);
    queue_cmd(MODE_PUSH_BACK, -32'sd1);
    queue_cmd(MODE_REMOVE, -32'sd1);
    queue_cmd(MODE_POP_FRONT, 32'sd0);
    queue_cmd(MODE_POP_BACK, 32'sd0);
    queue_cmd(MODE_SPARE_LO, 32'sd0);
    queue_cmd(MODE_SPARE_HI, -32'sd1);

    // fill past capacity, then work on a full queue
    repeat (CAPACITY + 2)
      queue_cmd($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
    queue_cmd(MODE_SHL, pick_value());
    queue_cmd(MODE_SHR, pick_value());
    queue_cmd(MODE_ROTL, 32'sd0);
    queue_cmd(MODE_ROTR, 32'sd0);
    queue_cmd(MODE_REVERSE, 32'sd0);
    queue_cmd(MODE_REMOVE, pick_value());
    queue_cmd(MODE_QUERY, 32'sd0);

    // random phases: grow, shrink or mix
    while (cmd_q.size() < N_ITEMS) begin
      kind = $urandom_range(0, 3);
      len = $urandom_range(20, 80);
      gen_quiet = ($urandom_range(0, 4) == 0);
      repeat (len) begin
        case (kind)
          0: begin
            if ($urandom_range(0, 9) < 8)
              m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else
              m = 4'($urandom_range(0, 15));
          end
          1: begin
            case ($urandom_range(0, 5))
              0: m = MODE_POP_FRONT;
              1: m = MODE_POP_BACK;
              2: m = MODE_SHL;
              3: m = MODE_SHR;
              4: m = MODE_REMOVE;
              default: m = 4'($urandom_range(0, 15));
            endcase
          end
          default: m = 4'($urandom_range(0, 15));
        endcase
        queue_cmd(m, pick_value());
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (cmd_q.size() != 0 || in_valid);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("deque_engine_with_rotate_reverse_remove verification clean");
    else
      $display("deque_engine_with_rotate_reverse_remove verification failed");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("deque_engine_with_rotate_reverse_remove verification failed");
    $finish;
  end

endmodule
